FILE: rtl/core/qn_pkg.sv
// ----------------------------------------------------------------------------
// qn_pkg: shared types and constants for the quaternion nlerp pipeline
// Component types, the per-lane root state and the stage counts.
// ----------------------------------------------------------------------------
package qn_pkg;

    localparam int ROOT_BITS    = 15;
    localparam int FRONT_STAGES = 7;
    localparam int DW           = 98;
    localparam int BW           = 81;

    localparam logic signed [15:0] UNIT_Q14 = 16'sd16384;

    typedef logic signed [15:0] t_comp;

    typedef struct packed {
        logic [14:0] blend;
        t_comp [3:0] second;
        t_comp [3:0] first;
    } t_in;

    // d: remaining margin m - u^2*s, b: u*s, with u = 2r-1
    typedef struct packed {
        logic signed [DW-1:0] d;
        logic signed [BW-1:0] b;
        logic [ROOT_BITS-1:0] r;
        logic                 neg;
    } t_lane;

    typedef struct packed {
        t_lane [3:0] lane;
        logic [63:0] s;
        logic        degen;
    } t_root;

endpackage

FILE: rtl/core/qn_blend.sv
// ----------------------------------------------------------------------------
// qn_blend: dot product, blend, squares and root seed
// Seven register stages from input pair to the first root state.
// ----------------------------------------------------------------------------
module qn_blend (
    input  logic          i_clk,
    input  logic [6:0]    i_en,
    input  qn_pkg::t_in   i_data,
    output qn_pkg::t_root o_root
);

    qn_pkg::t_comp [3:0] r0_a, r0_b, r1_a, r1_b;
    logic [14:0]         r0_t, r1_t;
    logic signed [31:0]  r0_p [4];
    logic                r1_dneg;
    logic signed [31:0]  r2_pa [4];
    logic signed [31:0]  r2_pb [4];
    logic [30:0]         r3_mag [4];
    logic [3:0]          r3_neg, r4_neg, r5_neg;
    logic [61:0]         r4_sq [4];
    logic [61:0]         r5_sq [4];
    logic [63:0]         r5_s;
    qn_pkg::t_root       r_root;

    logic signed [33:0]  w_dot;
    logic signed [15:0]  w_tq, w_teff, w_inv;
    logic signed [31:0]  w_c [4];
    logic [63:0]         w_s;

    always_comb begin
        w_dot  = 34'(r0_p[0]) + 34'(r0_p[1]) + 34'(r0_p[2]) + 34'(r0_p[3]);
        w_tq   = signed'({1'b0, r1_t});
        w_teff = r1_dneg ? -w_tq : w_tq;
        w_inv  = qn_pkg::UNIT_Q14 - w_tq;
        for (int i = 0; i < 4; i++) begin
            w_c[i] = r2_pa[i] + r2_pb[i];
        end
        w_s = 64'(r4_sq[0]) + 64'(r4_sq[1]) + 64'(r4_sq[2]) + 64'(r4_sq[3]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r0_a <= i_data.first;
            r0_b <= i_data.second;
            r0_t <= i_data.blend;
            for (int i = 0; i < 4; i++) begin
                r0_p[i] <= i_data.first[i] * i_data.second[i];
            end
        end
        if (i_en[1]) begin
            r1_a    <= r0_a;
            r1_b    <= r0_b;
            r1_t    <= r0_t;
            r1_dneg <= w_dot[33];
        end
        if (i_en[2]) begin
            // inv uses t before the shorter-arc negation
            for (int i = 0; i < 4; i++) begin
                r2_pa[i] <= r1_a[i] * w_inv;
                r2_pb[i] <= r1_b[i] * w_teff;
            end
        end
        if (i_en[3]) begin
            for (int i = 0; i < 4; i++) begin
                r3_neg[i] <= w_c[i][31];
                r3_mag[i] <= w_c[i][31] ? 31'(-w_c[i]) : w_c[i][30:0];
            end
        end
        if (i_en[4]) begin
            r4_neg <= r3_neg;
            for (int i = 0; i < 4; i++) begin
                r4_sq[i] <= r3_mag[i] * r3_mag[i];
            end
        end
        if (i_en[5]) begin
            r5_neg <= r4_neg;
            r5_s   <= w_s;
            for (int i = 0; i < 4; i++) begin
                r5_sq[i] <= r4_sq[i];
            end
        end
        if (i_en[6]) begin
            r_root.s     <= r5_s;
            r_root.degen <= (r5_s == 64'd0);
            for (int i = 0; i < 4; i++) begin
                r_root.lane[i].d   <= signed'({6'd0, r5_sq[i], 30'd0})
                                    - signed'({34'd0, r5_s});
                r_root.lane[i].b   <= -signed'({17'd0, r5_s});
                r_root.lane[i].r   <= '0;
                r_root.lane[i].neg <= r5_neg[i];
            end
        end
    end

    assign o_root = r_root;

endmodule

FILE: rtl/core/qn_root_step.sv
// ----------------------------------------------------------------------------
// qn_root_step: one digit of the rounded scaled root division
// Tries bit K of r on all four lanes: keeps it when (2r-1)^2*s <= mag^2*2^30.
// ----------------------------------------------------------------------------
module qn_root_step #(
    parameter int K = 14
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  qn_pkg::t_root i_root,
    output qn_pkg::t_root o_root
);

    qn_pkg::t_root               r_root;
    logic signed [qn_pkg::DW-1:0] w_sx, w_trial [4];
    logic signed [qn_pkg::BW-1:0] w_sb;
    logic signed [qn_pkg::DW-1:0] w_bx [4];
    logic [3:0]                   w_take;

    always_comb begin
        w_sx = signed'({34'd0, i_root.s});
        w_sb = signed'({17'd0, i_root.s});
        for (int i = 0; i < 4; i++) begin
            w_bx[i]    = {{(qn_pkg::DW - qn_pkg::BW){i_root.lane[i].b[qn_pkg::BW-1]}},
                          i_root.lane[i].b};
            w_trial[i] = i_root.lane[i].d - ((w_bx[i] <<< (K + 2)) + (w_sx <<< (2 * K + 2)));
            w_take[i]  = ~w_trial[i][qn_pkg::DW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_root.s     <= i_root.s;
            r_root.degen <= i_root.degen;
            for (int i = 0; i < 4; i++) begin
                r_root.lane[i].neg <= i_root.lane[i].neg;
                if (w_take[i]) begin
                    r_root.lane[i].d <= w_trial[i];
                    r_root.lane[i].b <= i_root.lane[i].b + (w_sb <<< (K + 1));
                    r_root.lane[i].r <= i_root.lane[i].r
                                      | (qn_pkg::ROOT_BITS'(1) << K);
                end else begin
                    r_root.lane[i].d <= i_root.lane[i].d;
                    r_root.lane[i].b <= i_root.lane[i].b;
                    r_root.lane[i].r <= i_root.lane[i].r;
                end
            end
        end
    end

    assign o_root = r_root;

endmodule

FILE: rtl/core/quaternion_nlerp.sv
// ----------------------------------------------------------------------------
// quaternion_nlerp: normalized linear interpolation of two quaternions
// Shorter-arc blend, exact length and round-to-nearest normalization.
// ----------------------------------------------------------------------------
//  channel  | dir | contents
//  s_axis   | in  | tdata: first x,y,z,w, second x,y,z,w (16b each), blend (15b)
//  m_axis   | out | tdata: out x,y,z,w (16b each); tuser: degenerate
//
// the pipeline has 7 blend/square stages, 15 root digit stages (one
// per result bit) and the output register; one pair enters every cycle unless a stall has backed up to the input.
// reset clears only the valid bits. a stall holds each full stage, while
// empty stages ahead of it keep filling, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module quaternion_nlerp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_axis_tvalid,
    output logic           o_s_axis_tready,
    input  logic [143:0]   i_s_axis_tdata,  // first x,y,z,w, second x,y,z,w, blend, pad
    output logic           o_m_axis_tvalid,
    input  logic           i_m_axis_tready,
    output logic [63:0]    o_m_axis_tdata,  // out x, out y, out z, out w
    output logic           o_m_axis_tuser   // degenerate
);

    localparam int NST = qn_pkg::FRONT_STAGES + qn_pkg::ROOT_BITS + 1;

    logic [NST-1:0] r_vld;
    logic [NST-1:0] w_en;
    qn_pkg::t_in    w_in;
    qn_pkg::t_root  w_root [qn_pkg::ROOT_BITS + 1];
    logic [63:0]    r_data;
    logic           r_degen;
    logic [63:0]    w_data;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_in.first[i]  = i_s_axis_tdata[16*i +: 16];
            w_in.second[i] = i_s_axis_tdata[64 + 16*i +: 16];
        end
        w_in.blend = i_s_axis_tdata[142:128];
    end

    // a stage loads when empty or when the stage behind it moves on
    always_comb begin
        w_en[NST-1] = ~r_vld[NST-1] | i_m_axis_tready;
        for (int k = NST - 2; k >= 0; k--) begin
            w_en[k] = ~r_vld[k] | w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    qn_blend u_blend (
        .i_clk  (i_clk),
        .i_en   (w_en[qn_pkg::FRONT_STAGES-1:0]),
        .i_data (w_in),
        .o_root (w_root[0])
    );

    for (genvar j = 0; j < qn_pkg::ROOT_BITS; j++) begin : g_root
        qn_root_step #(
            .K (qn_pkg::ROOT_BITS - 1 - j)
        ) u_step (
            .i_clk  (i_clk),
            .i_en   (w_en[qn_pkg::FRONT_STAGES + j]),
            .i_root (w_root[j]),
            .o_root (w_root[j+1])
        );
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (w_root[qn_pkg::ROOT_BITS].degen) begin
                w_data[16*i +: 16] = '0;
            end else if (w_root[qn_pkg::ROOT_BITS].lane[i].neg) begin
                w_data[16*i +: 16] = -{1'b0, w_root[qn_pkg::ROOT_BITS].lane[i].r};
            end else begin
                w_data[16*i +: 16] = {1'b0, w_root[qn_pkg::ROOT_BITS].lane[i].r};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[NST-1]) begin
            r_data  <= w_data;
            r_degen <= w_root[qn_pkg::ROOT_BITS].degen;
        end
    end

    assign o_s_axis_tready = w_en[0];
    assign o_m_axis_tvalid = r_vld[NST-1];
    assign o_m_axis_tdata  = r_data;
    assign o_m_axis_tuser  = r_degen;

endmodule
